>>> sv/ook_pulse_width_frame_decoder_core_assert.svh
// Assertion macros for the frame decoder modules; okd_queue uses them.
`ifndef OOK_PULSE_WIDTH_FRAME_DECODER_CORE_ASSERT_SVH
`define OOK_PULSE_WIDTH_FRAME_DECODER_CORE_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define OKD_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("okd assertion failed: expression does not hold");

// When the antecedent holds, the consequent holds in the same cycle.
`define OKD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("okd assertion failed: same-cycle implication");

// When the antecedent holds, the consequent holds in the next cycle.
`define OKD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("okd assertion failed: next-cycle implication");

`endif

>>> sv/okd_pkg.sv
// Types, constants and register codes of the OOK frame decoder.
`default_nettype none
package okd_pkg;

    localparam int FRAME_WIDTHS_DEF = 48;
    localparam int TICK_BITS        = 16;
    localparam int TICK_W           = 16;
    localparam int ADDR_W           = 20;
    localparam int KEY_W            = 4;
    localparam int SHIFT_W          = ADDR_W + KEY_W;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 48;
    localparam int M_USED_W         = ADDR_W + KEY_W + TICK_W + 1;

    localparam logic [TICK_W-1:0] TICK_MASK = (TICK_BITS >= TICK_W) ? {TICK_W{1'b1}} :
        TICK_W'((64'd1 << TICK_BITS) - 64'd1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NOISE_LIMIT = 2'd0,
        REG_SYNC_MIN    = 2'd1,
        REG_SYNC_MAX    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [TICK_W-1:0] noise_limit;
        logic [TICK_W-1:0] sync_min;
        logic [TICK_W-1:0] sync_max;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_SYNC   = 2'd0,
        OP_FIRST  = 2'd1,
        OP_SECOND = 2'd2
    } op_t;

    typedef enum logic {
        FRAME_HUNT = 1'b0,
        FRAME_DATA = 1'b1
    } frame_state_t;

    typedef struct packed {
        op_t               op;
        logic              last;
        logic [TICK_W-1:0] ticks;
    } work_t;

    typedef struct packed {
        logic              frame_status;
        logic [TICK_W-1:0] sync_ticks;
        logic [KEY_W-1:0]  key_code;
        logic [ADDR_W-1:0] address_code;
    } result_t;

endpackage
`default_nettype wire

>>> sv/ook_pulse_width_frame_decoder_core.sv
// Top level of the OOK pulse-width frame decoder with its configuration registers.
// Takes one radio-pin edge per word (level and ticks since the previous edge) and
// emits one word per decoded frame: the 20-bit address, 4-bit key, sync width and
// a noise flag. An edge is accepted every cycle; an accepted input word passes
// through the two-entry work queue and then the output register before a valid
// output word appears (the front filter is combinational), and the rate is set by the
// combinational pair compare in the bit decoder. Input accept pauses only when the
// queue fills behind a stalled output. Registers are to be written by the user
// through cfg_wr_en/cfg_index/cfg_wr_data only while the block is idle (not enforced):
// 0 noise_limit (reset 6), 1 sync_min (reset 400), 2 sync_max (reset 1200).
`default_nettype none
module ook_pulse_width_frame_decoder_core #(
    parameter int FRAME_WIDTHS = okd_pkg::FRAME_WIDTHS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [0] pin_level, [16:1] interval_ticks, [23:17] zero
    input  wire logic [okd_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [19:0] address_code, [23:20] key_code, [39:24] sync_ticks, [40] frame_status,
    // [47:41] zero
    output logic [okd_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [okd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [okd_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    okd_pkg::cfg_t    cfg_reg;
    okd_pkg::work_t   front_entry, queue_entry;
    okd_pkg::result_t result;
    logic             front_push, queue_ready, queue_valid, queue_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.noise_limit <= okd_pkg::TICK_W'(6);
            cfg_reg.sync_min    <= okd_pkg::TICK_W'(400);
            cfg_reg.sync_max    <= okd_pkg::TICK_W'(1200);
        end else if (cfg_wr_en) begin
            unique case (okd_pkg::cfg_reg_t'(cfg_index))
                okd_pkg::REG_NOISE_LIMIT: cfg_reg.noise_limit <= cfg_wr_data;
                okd_pkg::REG_SYNC_MIN:    cfg_reg.sync_min    <= cfg_wr_data;
                okd_pkg::REG_SYNC_MAX:    cfg_reg.sync_max    <= cfg_wr_data;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    okd_front #(
        .FRAME_WIDTHS(FRAME_WIDTHS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .pin_level      (s_tdata[0]),
        .interval_ticks (s_tdata[okd_pkg::TICK_W:1]),
        .cfg            (cfg_reg),
        .q_ready        (queue_ready),
        .q_push         (front_push),
        .q_entry        (front_entry)
    );

    okd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_push),
        .din     (front_entry),
        .ready   (queue_ready),
        .valid   (queue_valid),
        .dout    (queue_entry),
        .pop     (queue_pop)
    );

    okd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (queue_valid),
        .q_entry     (queue_entry),
        .q_pop       (queue_pop),
        .noise_limit (cfg_reg.noise_limit),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result)
    );

    assign m_tdata = {{(okd_pkg::M_TDATA_W - okd_pkg::M_USED_W){1'b0}}, result};

endmodule
`default_nettype wire

>>> sv/okd_front.sv
// Front end: filters edges, hunts for sync and tags each frame width.
`default_nettype none
module okd_front #(
    parameter int FRAME_WIDTHS = okd_pkg::FRAME_WIDTHS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          pin_level,
    input  wire logic [okd_pkg::TICK_W-1:0]    interval_ticks,
    input  wire okd_pkg::cfg_t                 cfg,
    input  wire logic                          q_ready,
    output logic                               q_push,
    output okd_pkg::work_t                     q_entry
);

    localparam int CW = (FRAME_WIDTHS > 2) ? $clog2(FRAME_WIDTHS) : 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_WIDTHS - 1);

    okd_pkg::frame_state_t state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  prev_level_reg;

    logic                        accept;
    logic [okd_pkg::TICK_W-1:0]  ticks_m;
    logic                        reject;
    logic                        is_sync;
    logic                        at_last;

    assign s_ready = q_ready;
    assign accept  = s_valid & q_ready;
    assign ticks_m = interval_ticks & okd_pkg::TICK_MASK;
    assign reject  = (ticks_m < cfg.noise_limit) || (pin_level == prev_level_reg) ||
                     (ticks_m > cfg.sync_max);
    assign is_sync = pin_level && (ticks_m > cfg.sync_min) && (ticks_m < cfg.sync_max);
    assign at_last = (count_reg == LAST_IDX);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        if (accept) begin
            if (reject) begin
                state_next = okd_pkg::FRAME_HUNT;
            end else begin
                unique case (state_reg)
                    okd_pkg::FRAME_HUNT: begin
                        if (is_sync) begin
                            state_next = okd_pkg::FRAME_DATA;
                            count_next = '0;
                        end
                    end
                    okd_pkg::FRAME_DATA: begin
                        if (at_last) begin
                            state_next = okd_pkg::FRAME_HUNT;
                            count_next = '0;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    default: state_next = okd_pkg::FRAME_HUNT;
                endcase
            end
        end
    end

    always_comb begin
        q_push        = 1'b0;
        q_entry.op    = okd_pkg::OP_SYNC;
        q_entry.last  = 1'b0;
        q_entry.ticks = ticks_m;
        if (accept && !reject) begin
            unique case (state_reg)
                okd_pkg::FRAME_HUNT: begin
                    q_push = is_sync;
                end
                okd_pkg::FRAME_DATA: begin
                    q_push       = 1'b1;
                    q_entry.op   = count_reg[0] ? okd_pkg::OP_SECOND : okd_pkg::OP_FIRST;
                    q_entry.last = at_last;
                end
                default: q_push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= okd_pkg::FRAME_HUNT;
            count_reg      <= '0;
            prev_level_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (accept) begin
                prev_level_reg <= pin_level;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/okd_queue.sv
// Short work queue between the front end and the bit decoder.
`default_nettype none
`include "ook_pulse_width_frame_decoder_core_assert.svh"
module okd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire okd_pkg::work_t  din,
    output logic                 ready,
    output logic                 valid,
    output okd_pkg::work_t       dout,
    input  wire logic            pop
);

    localparam int DEPTH = okd_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

    okd_pkg::work_t mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            do_push, do_pop;

    assign ready   = (count_reg != CNT_FULL);
    assign valid   = (count_reg != '0);
    assign dout    = mem[rd_ptr_reg];
    assign do_push = push & ready;
    assign do_pop  = pop & valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `OKD_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_FULL)
    `OKD_ASSERT_IMPL(a_no_push_when_full, aclk, aresetn, push, count_reg != CNT_FULL)
    `OKD_ASSERT_NEXT(a_push_grows, aclk, aresetn, do_push && !do_pop,
                     count_reg == $past(count_reg) + 1'b1)

endmodule
`default_nettype wire

>>> sv/okd_back.sv
// Back end: compares width pairs, shifts in bits and holds the finished frame.
`default_nettype none
module okd_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire okd_pkg::work_t              q_entry,
    output logic                             q_pop,
    input  wire logic [okd_pkg::TICK_W-1:0]  noise_limit,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output okd_pkg::result_t                 m_result
);

    logic [okd_pkg::TICK_W-1:0]  first_width_reg;
    logic [okd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic                        noisy_reg, noisy_next;
    logic [okd_pkg::TICK_W-1:0]  sync_reg;
    logic                        m_valid_reg;
    okd_pkg::result_t            m_result_reg;

    logic                        out_free;
    logic                        first_longer;
    logic [okd_pkg::TICK_W-1:0]  gap;
    logic                        pair_noisy;
    logic                        bit_val;
    logic                        emit;

    assign out_free = !m_valid_reg || m_ready;
    // A word that finishes a frame waits until the output register is free.
    assign q_pop    = q_valid && (!q_entry.last || out_free);
    assign emit     = q_pop && q_entry.last;

    assign first_longer = (first_width_reg > q_entry.ticks);
    assign gap          = first_longer ? (first_width_reg - q_entry.ticks)
                                       : (q_entry.ticks - first_width_reg);
    assign pair_noisy   = (gap < noise_limit);
    assign bit_val      = first_longer && !pair_noisy;

    always_comb begin
        shift_next = shift_reg;
        noisy_next = noisy_reg;
        unique case (q_entry.op)
            okd_pkg::OP_SYNC: begin
                shift_next = '0;
                noisy_next = 1'b0;
            end
            okd_pkg::OP_SECOND: begin
                shift_next = {shift_reg[okd_pkg::SHIFT_W-2:0], bit_val};
                noisy_next = noisy_reg | pair_noisy;
            end
            default: begin
                shift_next = shift_reg;
                noisy_next = noisy_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            shift_reg <= shift_next;
            noisy_reg <= noisy_next;
            if (q_entry.op == okd_pkg::OP_SYNC) begin
                sync_reg <= q_entry.ticks;
            end
            if (q_entry.op == okd_pkg::OP_FIRST) begin
                first_width_reg <= q_entry.ticks;
            end
        end
        if (emit) begin
            m_result_reg.address_code <= shift_next[okd_pkg::SHIFT_W-1:okd_pkg::KEY_W];
            m_result_reg.key_code     <= shift_next[okd_pkg::KEY_W-1:0];
            m_result_reg.sync_ticks   <= sync_reg;
            m_result_reg.frame_status <= noisy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule
`default_nettype wire
